// ===== design/gld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;
    localparam int DictEntries = 4096;
    localparam int MaxCodeBits = 12;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_PULL    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_INDEX    = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_NEED     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;
    localparam logic [2:0] ST_CORRUPT  = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;
    localparam logic [2:0] ST_LIMIT    = 3'd7;

    localparam logic REG_MIN_CODE_SIZE = 1'b0;
    localparam logic REG_PIXEL_LIMIT   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic restart;    // restart stream
        logic push;       // append byte
        logic extract;    // take a code from the bit buffer
        logic walk_start; // begin chain walk of the extracted code
        logic walk_step;  // one chain link onto the stack
        logic walk_fail;  // abandon walk, drop stack
        logic commit;     // add dictionary entry, update previous code
        logic pop;        // pop one index and count it
        logic set_final;  // latch terminal status
        logic [2:0] final_code;
    } t_cmd_bus;

    // datapath to controller
    typedef struct packed {
        logic       stack_empty;
        logic       limit_hit;
        logic       bits_short;
        logic       input_ended;
        logic       buf_full;
        logic [2:0] final_status;
        logic       is_clear;
        logic       is_end;
        logic       code_ok;
        logic       walk_done;
        logic       walk_bad;
    } t_status_bus;
endpackage
`default_nettype wire

// ===== design/gld_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gld_datapath #(
    parameter int DICT_ENTRIES  = gld_pkg::DictEntries,
    parameter int MAX_CODE_BITS = gld_pkg::MaxCodeBits
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_msz,
    input  wire  [3:0]            i_cfg_msz,
    input  wire                   i_cfg_wr_lim,
    input  wire  [31:0]           i_cfg_lim,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_final_byte,
    input  gld_pkg::t_cmd_bus     i_cmd,
    output gld_pkg::t_status_bus  o_sts,
    output logic [7:0]            o_pixel,
    output logic [31:0]           o_pixel_number
);
    import gld_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int CW = MAX_CODE_BITS;
    localparam int DW = AW + 1;
    localparam int WW = $clog2(MAX_CODE_BITS + 1);

    // dictionary and stack memories
    logic [CW-1:0] prefix_mem [DICT_ENTRIES];
    logic [7:0]    suffix_mem [DICT_ENTRIES];
    logic [7:0]    stack_mem  [DICT_ENTRIES];

    logic [3:0]    r_msz;
    logic [31:0]   r_limit;
    logic [31:0]   r_buf, n_buf;
    logic [5:0]    r_cnt, n_cnt;
    logic [DW-1:0] r_sp, n_sp;
    logic [CW:0]   r_next, n_next;
    logic [WW-1:0] r_width, n_width;
    logic [CW-1:0] r_prev, n_prev;
    logic [7:0]    r_pfirst, n_pfirst;
    logic          r_pvalid, n_pvalid;
    logic [31:0]   r_deliv, n_deliv;
    logic          r_ended, n_ended;
    logic [2:0]    r_final, n_final;
    logic [CW:0]   r_clear, n_clear;
    logic [CW-1:0] r_code;
    logic [CW-1:0] r_cur;
    logic          r_kwk;
    logic [CW-1:0] r_pre_q;
    logic [7:0]    r_suf_q;

    logic          do_restart;
    logic [3:0]    msz_sel;
    logic          msz_ok;
    logic [CW:0]   clear_new;
    logic [31:0]   mask;
    logic [CW-1:0] code_now;
    logic          cur_is_root;
    logic          kwk_now;
    logic [7:0]    walk_first;
    logic [AW-1:0] rd_addr;

    // a write of the minimum code size restarts the stream with the new value
    assign do_restart = i_cmd.restart || i_cfg_wr_msz;
    assign msz_sel    = i_cfg_wr_msz ? i_cfg_msz : r_msz;
    assign msz_ok     = (msz_sel >= 4'd2) && (msz_sel <= 4'd8);
    assign clear_new  = msz_ok ? ((CW+1)'(1) << msz_sel) : (CW+1)'(256);
    assign mask       = (32'd1 << r_width) - 32'd1;
    assign code_now   = CW'(r_buf & mask);
    assign cur_is_root = ({1'b0, r_cur} < r_clear);
    assign kwk_now    = ({1'b0, r_code} == r_next);
    assign walk_first = r_kwk ? r_pfirst : r_cur[7:0];

    // dictionary read address: chain start, then the prefix just read
    assign rd_addr = i_cmd.walk_start ? AW'(kwk_now ? r_prev : r_code) : AW'(r_pre_q);

    // memory reads and writes
    always_ff @(posedge i_clk) begin
        r_pre_q <= prefix_mem[rd_addr];
        r_suf_q <= suffix_mem[rd_addr];
        if (i_cmd.walk_step) begin
            stack_mem[AW'(r_sp)] <= cur_is_root ? r_cur[7:0] : r_suf_q;
        end else if (i_cmd.walk_start && kwk_now) begin
            stack_mem[0] <= r_pfirst;
        end
        if (i_cmd.commit && r_pvalid && (r_next < (CW+1)'(DICT_ENTRIES))) begin
            prefix_mem[AW'(r_next)] <= r_prev;
            suffix_mem[AW'(r_next)] <= walk_first;
        end
        if (i_cmd.pop) begin
            o_pixel <= stack_mem[AW'(r_sp - DW'(1))];
        end
    end

    // next state of control and payload registers
    always_comb begin
        n_buf = r_buf; n_cnt = r_cnt; n_sp = r_sp; n_next = r_next;
        n_width = r_width; n_prev = r_prev; n_pfirst = r_pfirst;
        n_pvalid = r_pvalid; n_deliv = r_deliv; n_ended = r_ended;
        n_final = r_final; n_clear = r_clear;
        if (do_restart) begin
            n_buf = '0; n_cnt = '0; n_sp = '0; n_deliv = '0;
            n_pvalid = 1'b0; n_prev = '0; n_pfirst = '0; n_ended = 1'b0;
            n_final = msz_ok ? ST_INDEX : ST_CORRUPT;
            n_clear = clear_new;
            n_width = msz_ok ? WW'(msz_sel + 4'd1) : WW'(9);
            n_next  = clear_new + (CW+1)'(2);
        end else begin
            if (i_cmd.push) begin
                n_buf   = r_buf | ({24'd0, i_data_byte} << r_cnt);
                n_cnt   = r_cnt + 6'd8;
                n_ended = i_final_byte;
            end
            if (i_cmd.extract) begin
                n_buf = r_buf >> r_width;
                n_cnt = r_cnt - 6'(r_width);
                if ({1'b0, code_now} == r_clear) begin
                    n_next   = r_clear + (CW+1)'(2);
                    n_width  = WW'(r_msz + 4'd1);
                    n_pvalid = 1'b0;
                end
            end
            if (i_cmd.walk_start) begin
                n_sp = kwk_now ? DW'(1) : '0;
            end
            if (i_cmd.walk_step) begin
                n_sp = r_sp + DW'(1);
            end
            if (i_cmd.walk_fail) begin
                n_sp = '0;
            end
            if (i_cmd.commit) begin
                if (r_pvalid && (r_next < (CW+1)'(DICT_ENTRIES))) begin
                    n_next = r_next + (CW+1)'(1);
                    if ((r_next + (CW+1)'(1)) == ((CW+1)'(1) << r_width)
                        && (r_width < WW'(MAX_CODE_BITS))) begin
                        n_width = r_width + WW'(1);
                    end
                end
                n_prev   = r_code;
                n_pfirst = walk_first;
                n_pvalid = 1'b1;
            end
            if (i_cmd.pop) begin
                n_sp    = r_sp - DW'(1);
                n_deliv = r_deliv + 32'd1;
            end
            if (i_cmd.set_final) begin
                n_final = i_cmd.final_code;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msz <= 4'd8; r_limit <= 32'd65536;
            r_buf <= '0; r_cnt <= '0; r_sp <= '0; r_next <= (CW+1)'(258);
            r_width <= WW'(9); r_prev <= '0; r_pfirst <= '0; r_pvalid <= 1'b0;
            r_deliv <= '0; r_ended <= 1'b0; r_final <= ST_INDEX;
            r_clear <= (CW+1)'(256);
        end else begin
            if (i_cfg_wr_msz) r_msz <= i_cfg_msz;
            if (i_cfg_wr_lim) r_limit <= i_cfg_lim;
            r_buf <= n_buf; r_cnt <= n_cnt; r_sp <= n_sp; r_next <= n_next;
            r_width <= n_width; r_prev <= n_prev; r_pfirst <= n_pfirst;
            r_pvalid <= n_pvalid; r_deliv <= n_deliv; r_ended <= n_ended;
            r_final <= n_final; r_clear <= n_clear;
        end
    end

    // walk registers: current code, chain position, kwkwk flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.extract) begin
            r_code <= code_now;
        end
        if (i_cmd.walk_start) begin
            r_cur <= kwk_now ? r_prev : r_code;
            r_kwk <= kwk_now;
        end else if (i_cmd.walk_step && !cur_is_root) begin
            r_cur <= r_pre_q;
        end
    end

    assign o_pixel_number = r_deliv;

    // status toward the controller
    always_comb begin
        o_sts.stack_empty  = (r_sp == '0);
        o_sts.limit_hit    = (r_deliv >= r_limit);
        o_sts.bits_short   = (r_cnt < 6'(r_width));
        o_sts.input_ended  = r_ended;
        o_sts.buf_full     = (r_cnt > 6'd24);
        o_sts.final_status = r_final;
        o_sts.is_clear     = ({1'b0, code_now} == r_clear);
        o_sts.is_end       = ({1'b0, code_now} == r_clear + (CW+1)'(1));
        o_sts.code_ok      = ({1'b0, code_now} < r_next)
                           || (({1'b0, code_now} == r_next) && r_pvalid);
        o_sts.walk_done    = cur_is_root;
        o_sts.walk_bad     = (!cur_is_root && ({1'b0, r_cur} >= (CW+1)'(DICT_ENTRIES)))
                           || (r_sp >= DW'(DICT_ENTRIES));
    end
endmodule
`default_nettype wire

// ===== design/gld_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gld_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [1:0]           i_cmd,
    input  gld_pkg::t_status_bus i_sts,
    output gld_pkg::t_cmd_bus    o_dp,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [2:0]           o_status,
    output logic                 o_pixel_sel
);
    import gld_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_WSTART = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_POP    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_status, n_status;
    logic       r_popped, n_popped;
    logic       take;

    assign take    = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_pixel_sel = r_popped;

    // sequencer
    always_comb begin
        n_state = r_state; n_status = r_status; n_popped = r_popped;
        o_dp = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_popped = 1'b0;
                    n_state  = S_OUT;
                    if (t_cmd'(i_cmd) == CMD_RESTART) begin
                        o_dp.restart = 1'b1;
                        n_status = ST_ACCEPTED;
                        n_state  = S_INIT; // final status known next cycle
                    end else if (t_cmd'(i_cmd) == CMD_UNUSED) begin
                        n_status = ST_REFUSED;
                    end else if (i_sts.final_status != ST_INDEX) begin
                        n_status = i_sts.final_status;
                    end else if (t_cmd'(i_cmd) == CMD_PUSH) begin
                        if (i_sts.input_ended || i_sts.buf_full) begin
                            n_status = ST_REFUSED;
                        end else begin
                            o_dp.push = 1'b1;
                            n_status  = ST_ACCEPTED;
                        end
                    end else if (!i_sts.stack_empty) begin
                        if (i_sts.limit_hit) begin
                            o_dp.set_final  = 1'b1;
                            o_dp.final_code = ST_LIMIT;
                            n_status = ST_LIMIT;
                        end else begin
                            o_dp.pop = 1'b1;
                            n_popped = 1'b1;
                            n_status = ST_INDEX;
                        end
                    end else if (i_sts.limit_hit) begin
                        o_dp.set_final  = 1'b1;
                        o_dp.final_code = ST_DONE;
                        n_status = ST_DONE;
                    end else begin
                        n_status = ST_INDEX;
                        n_state  = S_FETCH;
                    end
                end
            end
            S_INIT: begin
                // after restart: report corrupt size if flagged
                if (i_sts.final_status != ST_INDEX) n_status = i_sts.final_status;
                n_state = S_OUT;
            end
            S_FETCH: begin
                // take codes until a string is ready, more input is needed or the stream ends
                n_state = S_OUT;
                if (i_sts.bits_short) begin
                    if (i_sts.input_ended) begin
                        o_dp.set_final  = 1'b1;
                        o_dp.final_code = ST_TRUNC;
                        n_status = ST_TRUNC;
                    end else begin
                        n_status = ST_NEED;
                    end
                end else begin
                    o_dp.extract = 1'b1;
                    if (i_sts.is_clear) begin
                        n_state = S_FETCH;
                    end else if (i_sts.is_end) begin
                        o_dp.set_final  = 1'b1;
                        o_dp.final_code = ST_DONE;
                        n_status = ST_DONE;
                    end else if (!i_sts.code_ok) begin
                        o_dp.set_final  = 1'b1;
                        o_dp.final_code = ST_CORRUPT;
                        n_status = ST_CORRUPT;
                    end else begin
                        n_state = S_WSTART;
                    end
                end
            end
            S_WSTART: begin
                // load the chain start and issue its dictionary read
                o_dp.walk_start = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                // one chain link per cycle onto the stack
                if (i_sts.walk_bad) begin
                    o_dp.walk_fail  = 1'b1;
                    o_dp.set_final  = 1'b1;
                    o_dp.final_code = ST_CORRUPT;
                    n_status = ST_CORRUPT;
                    n_state  = S_OUT;
                end else begin
                    o_dp.walk_step = 1'b1;
                    if (i_sts.walk_done) begin
                        o_dp.commit = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                // deliver the first index of the new string
                o_dp.pop = 1'b1;
                n_popped = 1'b1;
                n_status = ST_INDEX;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_INDEX;
            r_popped <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end
endmodule
`default_nettype wire

// ===== design/gif_lzw_decoder.sv =====
// gif_lzw_decoder: streaming GIF LZW decoder
// push, pull from the stack or terminal answer: result registered in S_OUT; restart goes through S_INIT first
// a pull that decodes a new code steps S_FETCH (again for each clear code), S_WSTART, S_WALK per link, S_POP, S_OUT
// one item at a time: no new input is taken until the result has been transferred
// reset: synchronous active low; dictionary and stack memories are not cleared
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_decoder #(
    parameter int DICT_ENTRIES  = gld_pkg::DictEntries,
    parameter int MAX_CODE_BITS = gld_pkg::MaxCodeBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_cmd,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_final_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_pixel,
    output logic [31:0] o_pixel_number,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import gld_pkg::*;

    t_cmd_bus    dp_cmd;
    t_status_bus dp_sts;
    logic [7:0]  dp_pixel;
    logic        pixel_sel;
    logic        wr_msz;

    assign o_cfg_ready = 1'b1;
    assign wr_msz = i_cfg_valid && (i_cfg_index == REG_MIN_CODE_SIZE);

    gld_datapath #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_wr_msz (wr_msz),
        .i_cfg_msz    (i_cfg_data[3:0]),
        .i_cfg_wr_lim (i_cfg_valid && (i_cfg_index == REG_PIXEL_LIMIT)),
        .i_cfg_lim    (i_cfg_data),
        .i_data_byte, .i_final_byte,
        .i_cmd (dp_cmd),
        .o_sts (dp_sts),
        .o_pixel (dp_pixel),
        .o_pixel_number
    );

    gld_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd,
        .i_sts (dp_sts), .o_dp (dp_cmd),
        .o_valid, .i_stall, .o_status, .o_pixel_sel (pixel_sel)
    );

    assign o_pixel = pixel_sel ? dp_pixel : 8'd0;

    // a result never appears while an input is being taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while input open");
    // a delivered index comes with a nonzero pixel count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_status == ST_INDEX) |-> o_pixel_number != 32'd0)
        else $error("index delivered with zero count");
    // pixel is zero with any shown result that is not an index
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_INDEX) |-> o_pixel == 8'd0)
        else $error("stray pixel value");
endmodule
`default_nettype wire
